// File: design/gfpn_pkg.sv
// Shared types and constants for the gamepad frame parser.
package gfpn_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int NUM_CFG_REGS = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RIGHT_Y_LOW  = 3'd0,
        REG_RIGHT_Y_HIGH = 3'd1,
        REG_RIGHT_X_LOW  = 3'd2,
        REG_RIGHT_X_HIGH = 3'd3,
        REG_LEFT_Y_LOW   = 3'd4,
        REG_LEFT_Y_HIGH  = 3'd5,
        REG_LEFT_X_LOW   = 3'd6,
        REG_LEFT_X_HIGH  = 3'd7
    } cfg_idx_t;

    localparam logic [7:0] DZ_LOW_RST  = 8'd118;
    localparam logic [7:0] DZ_HIGH_RST = 8'd138;

    // Frame framing bytes
    localparam logic [7:0] HDR_FIRST  = 8'h01;
    localparam logic [7:0] HDR_SECOND = 8'h02;
    localparam logic [7:0] TAIL_FIRST = 8'h03;
    localparam logic [7:0] TAIL_LAST  = 8'h04;

    // Payload: 11 bytes, the last one is taken straight from the link
    localparam int PAYLOAD_LEN = 11;
    localparam int STORE_DEPTH = PAYLOAD_LEN - 1;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_LAST = 4'(PAYLOAD_LEN - 1);

    localparam logic [CNT_W-1:0] POS_BTN_A    = 4'd0;
    localparam logic [CNT_W-1:0] POS_BTN_B    = 4'd1;
    localparam logic [CNT_W-1:0] POS_LX       = 4'd2;
    localparam logic [CNT_W-1:0] POS_LY       = 4'd3;
    localparam logic [CNT_W-1:0] POS_RX       = 4'd4;
    localparam logic [CNT_W-1:0] POS_RY       = 4'd5;
    localparam logic [CNT_W-1:0] POS_TRIG_L   = 4'd6;
    localparam logic [CNT_W-1:0] POS_TRIG_R   = 4'd7;
    localparam logic [CNT_W-1:0] POS_BTN_C    = 4'd8;
    localparam logic [CNT_W-1:0] POS_TAIL_0   = 4'd9;

    // Axis scaling: floor(d * 16384 / 100) == (d * ceil(2^24/25)) >> 12
    // for every 8-bit d.
    localparam int AXIS_RECIP_W = 20;
    localparam logic [AXIS_RECIP_W-1:0] AXIS_RECIP = 20'd671089;
    localparam int AXIS_SHIFT = 12;
    localparam int AXIS_PROD_W = 8 + AXIS_RECIP_W;
    localparam logic [15:0] AXIS_FULL = 16'd16384;

    typedef struct packed {
        logic [7:0] right_y_low;
        logic [7:0] right_y_high;
        logic [7:0] right_x_low;
        logic [7:0] right_x_high;
        logic [7:0] left_y_low;
        logic [7:0] left_y_high;
        logic [7:0] left_x_low;
        logic [7:0] left_x_high;
    } thresh_t;

    typedef struct packed {
        logic [7:0] buttons_a;
        logic [7:0] buttons_b;
        logic [7:0] buttons_c;
        logic [7:0] left_x_raw;
        logic [7:0] left_y_raw;
        logic [7:0] right_x_raw;
        logic [7:0] right_y_raw;
        logic [7:0] trig_left_raw;
        logic [7:0] trig_right_raw;
    } frame_t;

    typedef struct packed {
        logic [7:0]         buttons_a;
        logic [7:0]         buttons_b;
        logic [7:0]         buttons_c;
        logic signed [15:0] left_x_norm;
        logic signed [15:0] left_y_norm;
        logic signed [15:0] right_x_norm;
        logic signed [15:0] right_y_norm;
        logic [15:0]        trigger_left;
        logic [15:0]        trigger_right;
    } result_t;

endpackage

// File: design/gfpn_if.sv
// Stream interfaces: received byte channel and gamepad report channel.
interface gfpn_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gfpn_report_if;
    logic               valid;
    logic               ready;
    logic [7:0]         buttons_a;
    logic [7:0]         buttons_b;
    logic [7:0]         buttons_c;
    logic signed [15:0] left_x_norm;
    logic signed [15:0] left_y_norm;
    logic signed [15:0] right_x_norm;
    logic signed [15:0] right_y_norm;
    logic [15:0]        trigger_left;
    logic [15:0]        trigger_right;

    modport source (
        output valid, input ready,
        output buttons_a, output buttons_b, output buttons_c,
        output left_x_norm, output left_y_norm, output right_x_norm, output right_y_norm,
        output trigger_left, output trigger_right
    );
    modport sink (
        input valid, output ready,
        input buttons_a, input buttons_b, input buttons_c,
        input left_x_norm, input left_y_norm, input right_x_norm, input right_y_norm,
        input trigger_left, input trigger_right
    );
endinterface

// File: design/gfpn_cfg_regs.sv
// APB register bank holding the stick dead-zone thresholds.
module gfpn_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gfpn_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gfpn_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gfpn_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output gfpn_pkg::thresh_t                   thresh
);

    logic [7:0]                       cfg_reg [gfpn_pkg::NUM_CFG_REGS];
    logic [gfpn_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[gfpn_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign prdata  = {(gfpn_pkg::APB_DATA_W - 8)'(0), cfg_reg[reg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gfpn_pkg::NUM_CFG_REGS; i++)
            begin
                // even slots are low edges, odd slots high edges
                cfg_reg[i] <= (i % 2 == 1) ? gfpn_pkg::DZ_HIGH_RST : gfpn_pkg::DZ_LOW_RST;
            end
        end
        else if (wr_en)
        begin
            cfg_reg[reg_idx] <= pwdata[7:0];
        end
    end

    assign thresh.right_y_low  = cfg_reg[gfpn_pkg::REG_RIGHT_Y_LOW];
    assign thresh.right_y_high = cfg_reg[gfpn_pkg::REG_RIGHT_Y_HIGH];
    assign thresh.right_x_low  = cfg_reg[gfpn_pkg::REG_RIGHT_X_LOW];
    assign thresh.right_x_high = cfg_reg[gfpn_pkg::REG_RIGHT_X_HIGH];
    assign thresh.left_y_low   = cfg_reg[gfpn_pkg::REG_LEFT_Y_LOW];
    assign thresh.left_y_high  = cfg_reg[gfpn_pkg::REG_LEFT_Y_HIGH];
    assign thresh.left_x_low   = cfg_reg[gfpn_pkg::REG_LEFT_X_LOW];
    assign thresh.left_x_high  = cfg_reg[gfpn_pkg::REG_LEFT_X_HIGH];

endmodule

// File: design/gfpn_framer.sv
// Frame sync, payload capture and tail check; registers a complete frame.
module gfpn_framer
(
    input  logic              clk,
    input  logic              rst_n,
    gfpn_byte_if.sink         rx,
    input  logic              frame_take,
    output logic              frame_valid,
    output gfpn_pkg::frame_t  frame
);

    typedef enum logic [1:0] {
        ST_HUNT    = 2'd0,
        ST_HDR     = 2'd1,
        ST_PAYLOAD = 2'd2
    } state_t;

    state_t                        state_reg, state_next;
    logic [gfpn_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          frame_valid_reg, frame_valid_next;
    logic [7:0]                    store_reg [gfpn_pkg::STORE_DEPTH];
    gfpn_pkg::frame_t              frame_reg, frame_next;
    logic                          acc;
    logic                          done;
    logic                          tail_ok;

    // frame slot can refill in the same cycle it drains
    assign rx.ready = !frame_valid_reg || frame_take;
    assign acc      = rx.valid && rx.ready;
    assign tail_ok  = (store_reg[gfpn_pkg::POS_TAIL_0] == gfpn_pkg::TAIL_FIRST)
                   && (rx.rx_byte == gfpn_pkg::TAIL_LAST);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done       = 1'b0;
        if (acc)
        begin
            unique case (state_reg)
                ST_HDR:
                begin
                    // a wrong second byte is dropped, not rechecked as a header
                    state_next = (rx.rx_byte == gfpn_pkg::HDR_SECOND) ? ST_PAYLOAD : ST_HUNT;
                    count_next = '0;
                end
                ST_PAYLOAD:
                begin
                    if (count_reg == gfpn_pkg::CNT_LAST)
                    begin
                        state_next = ST_HUNT;
                        count_next = '0;
                        done       = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = (rx.rx_byte == gfpn_pkg::HDR_FIRST) ? ST_HDR : ST_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (frame_valid_reg && !frame_take)
        begin
            frame_valid_next = 1'b1;
        end
        else
        begin
            frame_valid_next = done && tail_ok;
        end
    end

    always_comb
    begin
        frame_next.buttons_a      = store_reg[gfpn_pkg::POS_BTN_A];
        frame_next.buttons_b      = store_reg[gfpn_pkg::POS_BTN_B];
        frame_next.buttons_c      = store_reg[gfpn_pkg::POS_BTN_C];
        frame_next.left_x_raw     = store_reg[gfpn_pkg::POS_LX];
        frame_next.left_y_raw     = store_reg[gfpn_pkg::POS_LY];
        frame_next.right_x_raw    = store_reg[gfpn_pkg::POS_RX];
        frame_next.right_y_raw    = store_reg[gfpn_pkg::POS_RY];
        frame_next.trig_left_raw  = store_reg[gfpn_pkg::POS_TRIG_L];
        frame_next.trig_right_raw = store_reg[gfpn_pkg::POS_TRIG_R];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_HUNT;
            count_reg       <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    // payload bytes, no reset
    always_ff @(posedge clk)
    begin
        if (acc && state_reg == ST_PAYLOAD && count_reg != gfpn_pkg::CNT_LAST)
        begin
            store_reg[count_reg] <= rx.rx_byte;
        end
        if (done && tail_ok && rx.ready)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gfpn_pkg::CNT_LAST)
        else $error("payload count past last byte");

    a_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (state_reg == ST_PAYLOAD))
        else $error("payload count running outside payload phase");

    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid_reg && !frame_take) |=> (frame_valid_reg && $stable(frame_reg)))
        else $error("pending frame lost or changed");
`endif

endmodule

// File: design/gfpn_axis.sv
// One stick axis: dead-zone test and scaling to signed Q1.14.
module gfpn_axis
(
    input  logic [7:0]         raw,
    input  logic [7:0]         lo,
    input  logic [7:0]         hi,
    output logic signed [15:0] norm
);

    logic                                below;
    logic                                above;
    logic [7:0]                          delta;
    logic [gfpn_pkg::AXIS_PROD_W-1:0]    prod;
    logic [15:0]                         quot;
    logic [15:0]                         mag;

    assign below = raw < lo;
    assign above = raw > hi;
    assign delta = below ? (lo - raw) : (raw - hi);
    assign prod  = gfpn_pkg::AXIS_PROD_W'(delta)
                 * gfpn_pkg::AXIS_PROD_W'(gfpn_pkg::AXIS_RECIP);
    assign quot  = prod[gfpn_pkg::AXIS_SHIFT +: 16];
    assign mag   = (quot > gfpn_pkg::AXIS_FULL) ? gfpn_pkg::AXIS_FULL : quot;

    always_comb
    begin
        priority if (below)
        begin
            norm = $signed(mag);
        end
        else if (above)
        begin
            norm = -$signed(mag);
        end
        else
        begin
            norm = '0;
        end
    end

endmodule

// File: design/gfpn_normalize.sv
// Scales a captured frame into a report and holds it in the result register.
module gfpn_normalize
(
    input  logic               clk,
    input  logic               rst_n,
    input  gfpn_pkg::thresh_t  thresh,
    input  logic               frame_valid,
    input  gfpn_pkg::frame_t   frame,
    output logic               frame_take,
    gfpn_report_if.source      report
);

    gfpn_pkg::result_t  res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    gfpn_axis u_axis_lx (
        .raw  (frame.left_x_raw),
        .lo   (thresh.left_x_low),
        .hi   (thresh.left_x_high),
        .norm (res_next.left_x_norm)
    );

    gfpn_axis u_axis_ly (
        .raw  (frame.left_y_raw),
        .lo   (thresh.left_y_low),
        .hi   (thresh.left_y_high),
        .norm (res_next.left_y_norm)
    );

    gfpn_axis u_axis_rx (
        .raw  (frame.right_x_raw),
        .lo   (thresh.right_x_low),
        .hi   (thresh.right_x_high),
        .norm (res_next.right_x_norm)
    );

    gfpn_axis u_axis_ry (
        .raw  (frame.right_y_raw),
        .lo   (thresh.right_y_low),
        .hi   (thresh.right_y_high),
        .norm (res_next.right_y_norm)
    );

    assign res_next.buttons_a     = frame.buttons_a;
    assign res_next.buttons_b     = frame.buttons_b;
    assign res_next.buttons_c     = frame.buttons_c;
    // raw * 257 is the byte repeated
    assign res_next.trigger_left  = {frame.trig_left_raw, frame.trig_left_raw};
    assign res_next.trigger_right = {frame.trig_right_raw, frame.trig_right_raw};

    assign frame_take     = !res_valid_reg || report.ready;
    assign res_valid_next = frame_take ? frame_valid : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take && frame_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign report.valid         = res_valid_reg;
    assign report.buttons_a     = res_reg.buttons_a;
    assign report.buttons_b     = res_reg.buttons_b;
    assign report.buttons_c     = res_reg.buttons_c;
    assign report.left_x_norm   = res_reg.left_x_norm;
    assign report.left_y_norm   = res_reg.left_y_norm;
    assign report.right_x_norm  = res_reg.right_x_norm;
    assign report.right_y_norm  = res_reg.right_y_norm;
    assign report.trigger_left  = res_reg.trigger_left;
    assign report.trigger_right = res_reg.trigger_right;

`ifndef SYNTHESIS
    a_frame_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_take) |=> res_valid_reg)
        else $error("taken frame did not reach the result register");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.left_x_norm >= -16'sd16384
                        && res_reg.left_x_norm <= 16'sd16384
                        && res_reg.right_y_norm >= -16'sd16384
                        && res_reg.right_y_norm <= 16'sd16384))
        else $error("axis value outside Q1.14 unit range");

    a_trigger_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.trigger_left[15:8] == res_reg.trigger_left[7:0]
                        && res_reg.trigger_right[15:8] == res_reg.trigger_right[7:0]))
        else $error("trigger not a byte times 257");
`endif

endmodule

// File: design/gamepad_frame_parse_normalize_core.sv
// A good frame passes through the frame register, then the result register, which drives report valid.
// Throughput: one received byte per cycle; frame register and result register stall
// only when the report sink holds ready low with both of them full.
// Reset (rst_n, async, active low): hunting for the first header byte, no frame or
// report pending, thresholds at 118 (low) and 138 (high); payload bytes are not cleared.
// Top level: APB threshold registers, byte framer and report normalizer.
module gamepad_frame_parse_normalize_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    gfpn_byte_if.sink                        rx,
    gfpn_report_if.source                    report,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gfpn_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gfpn_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gfpn_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    // Thresholds feed the normalizer directly; the user must see they are only written while idle,
    // so a frame in flight always sees a settled set; the block itself does not enforce this.
    gfpn_pkg::thresh_t  thresh;

    // Frame register handshake between framer and normalizer.
    logic               frame_valid;
    logic               frame_take;
    gfpn_pkg::frame_t   frame;

    gfpn_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thresh  (thresh)
    );

    // Hunts 0x01 0x02, collects the 11-byte payload, checks the 0x03 0x04 tail
    // and registers the good frame in one step with the last byte.
    gfpn_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .frame_take  (frame_take),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    // Dead-zone and scaling for four axes in parallel, triggers as byte*257,
    // result register drives the report request.
    gfpn_normalize u_normalize (
        .clk         (clk),
        .rst_n       (rst_n),
        .thresh      (thresh),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take),
        .report      (report)
    );

endmodule
